FILE: sv/ftr_pkg.sv
// Shared types, codes and font table for the text rectangle renderer.
// Used by ftr_ctrl, ftr_dp and the top level; depends on nothing.
package ftr_pkg;

  // Configuration register indexes (word address)
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_FORE_COLOR  = 3'd2;
  localparam logic [2:0] REG_BACK_COLOR  = 3'd3;
  localparam logic [2:0] REG_PIXEL_SCALE = 3'd4;

  // Draw kinds on the result word
  localparam logic DRAW_FILL    = 1'b0;
  localparam logic DRAW_OUTLINE = 1'b1;

  // Special character codes
  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  // Glyph geometry
  localparam logic [2:0] GLYPH_LAST_COL = 3'd4;
  localparam logic [2:0] GLYPH_LAST_ROW = 3'd6;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_NEWLINE,
    CLS_SPACE,
    CLS_OTHER,
    CLS_GLYPH
  } ftr_cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPACE,
    S_FILL,
    S_OUTLINE,
    S_GLYPH
  } ftr_state_t;

  typedef enum logic [1:0] {
    OP_SPACE,
    OP_FILL,
    OP_OUTLINE,
    OP_PIXEL
  } ftr_op_t;

  // Controller to datapath
  typedef struct packed {
    logic    in_ready;
    logic    emit;
    ftr_op_t op;
    logic    advance;
  } ftr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic     in_valid;
    ftr_cls_t in_cls;
    logic     last_px;
    logic     out_free;
  } ftr_sts_t;

  // 5x7 font, A-Z then 0-9; each entry is one column, bit 0 the top row
  localparam logic [6:0] GLYPH_ROM [36][5] = '{
    '{7'h1E, 7'h05, 7'h05, 7'h05, 7'h1E}, '{7'h1F, 7'h15, 7'h15, 7'h15, 7'h0A},
    '{7'h0E, 7'h11, 7'h11, 7'h11, 7'h11}, '{7'h1F, 7'h11, 7'h11, 7'h11, 7'h0E},
    '{7'h1F, 7'h15, 7'h15, 7'h11, 7'h11}, '{7'h1F, 7'h05, 7'h05, 7'h01, 7'h01},
    '{7'h0E, 7'h11, 7'h15, 7'h15, 7'h1D}, '{7'h1F, 7'h04, 7'h04, 7'h04, 7'h1F},
    '{7'h11, 7'h11, 7'h1F, 7'h11, 7'h11}, '{7'h08, 7'h10, 7'h10, 7'h10, 7'h0F},
    '{7'h1F, 7'h04, 7'h0A, 7'h11, 7'h11}, '{7'h1F, 7'h10, 7'h10, 7'h10, 7'h10},
    '{7'h1F, 7'h02, 7'h04, 7'h02, 7'h1F}, '{7'h1F, 7'h02, 7'h04, 7'h08, 7'h1F},
    '{7'h0E, 7'h11, 7'h11, 7'h11, 7'h0E}, '{7'h1F, 7'h05, 7'h05, 7'h05, 7'h02},
    '{7'h0E, 7'h11, 7'h19, 7'h11, 7'h1E}, '{7'h1F, 7'h05, 7'h0D, 7'h15, 7'h12},
    '{7'h12, 7'h15, 7'h15, 7'h15, 7'h09}, '{7'h01, 7'h01, 7'h1F, 7'h01, 7'h01},
    '{7'h0F, 7'h10, 7'h10, 7'h10, 7'h0F}, '{7'h07, 7'h08, 7'h10, 7'h08, 7'h07},
    '{7'h1F, 7'h08, 7'h04, 7'h08, 7'h1F}, '{7'h11, 7'h0A, 7'h04, 7'h0A, 7'h11},
    '{7'h03, 7'h04, 7'h18, 7'h04, 7'h03}, '{7'h19, 7'h15, 7'h15, 7'h13, 7'h11},
    '{7'h0E, 7'h13, 7'h15, 7'h19, 7'h0E}, '{7'h00, 7'h12, 7'h1F, 7'h10, 7'h00},
    '{7'h12, 7'h19, 7'h15, 7'h15, 7'h12}, '{7'h11, 7'h15, 7'h15, 7'h15, 7'h0A},
    '{7'h07, 7'h04, 7'h04, 7'h1F, 7'h04}, '{7'h17, 7'h15, 7'h15, 7'h15, 7'h09},
    '{7'h0E, 7'h15, 7'h15, 7'h15, 7'h08}, '{7'h01, 7'h01, 7'h19, 7'h05, 7'h03},
    '{7'h0A, 7'h15, 7'h15, 7'h15, 7'h0A}, '{7'h02, 7'h15, 7'h15, 7'h15, 7'h0E}
  };

  // Sort a character code into the kind of drawing it needs
  function automatic ftr_cls_t char_class(input logic [7:0] code);
    ftr_cls_t cls;
    if (code == CHAR_NUL) begin
      cls = CLS_NONE;
    end else if (code == CHAR_NEWLINE) begin
      cls = CLS_NEWLINE;
    end else if (code == CHAR_SPACE) begin
      cls = CLS_SPACE;
    end else if ((code >= 8'h41 && code <= 8'h5A) || (code >= 8'h61 && code <= 8'h7A) ||
                 (code >= 8'h30 && code <= 8'h39)) begin
      cls = CLS_GLYPH;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  // Font table row for a letter or digit; lowercase folds to uppercase
  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [7:0] idx;
    if (code >= 8'h61) begin
      idx = code - 8'h61;
    end else if (code >= 8'h41) begin
      idx = code - 8'h41;
    end else begin
      idx = code - 8'h30 + 8'd26;
    end
    return idx[5:0];
  endfunction

endpackage

FILE: sv/ftr_if.sv
// Handshake channels of the text rectangle renderer: character words in,
// rectangle command words out. No dependencies.
interface ftr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       string_start;

  modport source (output valid, char_code, string_start, input ready);
  modport sink   (input valid, char_code, string_start, output ready);
endinterface

interface ftr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] rect_x;
  logic [15:0] rect_y;
  logic [10:0] rect_w;
  logic [10:0] rect_h;
  logic [15:0] rect_color;
  logic        draw_kind;
  logic        last_of_char;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, rect_color, draw_kind,
                  last_of_char, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, rect_color, draw_kind,
                  last_of_char, output ready);
endinterface

FILE: sv/ftr_ctrl.sv
// Sequencer of the text rectangle renderer: takes one character word and
// steps through its rectangle commands. Depends on ftr_pkg.
module ftr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  ftr_pkg::ftr_sts_t sts,
  output ftr_pkg::ftr_cmd_t cmd
);

  ftr_pkg::ftr_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ftr_pkg::S_IDLE: begin
        if (sts.in_valid) begin
          case (sts.in_cls)
            ftr_pkg::CLS_SPACE: state_nxt = ftr_pkg::S_SPACE;
            ftr_pkg::CLS_OTHER: state_nxt = ftr_pkg::S_FILL;
            ftr_pkg::CLS_GLYPH: state_nxt = ftr_pkg::S_GLYPH;
            default:            state_nxt = ftr_pkg::S_IDLE;
          endcase
        end
      end
      ftr_pkg::S_SPACE: begin
        if (sts.out_free) state_nxt = ftr_pkg::S_IDLE;
      end
      ftr_pkg::S_FILL: begin
        if (sts.out_free) state_nxt = ftr_pkg::S_OUTLINE;
      end
      ftr_pkg::S_OUTLINE: begin
        if (sts.out_free) state_nxt = ftr_pkg::S_IDLE;
      end
      ftr_pkg::S_GLYPH: begin
        if (sts.out_free && sts.last_px) state_nxt = ftr_pkg::S_IDLE;
      end
      default: state_nxt = ftr_pkg::S_IDLE;
    endcase
  end

  // Commands: take input words in idle; in the other states emit a word whenever the output register has room
  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.emit     = 1'b0;
    cmd.op       = ftr_pkg::OP_PIXEL;
    cmd.advance  = 1'b0;
    case (state_r)
      ftr_pkg::S_IDLE: begin
        // hold off input words while in reset
        cmd.in_ready = rst_n;
      end
      ftr_pkg::S_SPACE: begin
        cmd.emit    = sts.out_free;
        cmd.op      = ftr_pkg::OP_SPACE;
        cmd.advance = sts.out_free;
      end
      ftr_pkg::S_FILL: begin
        cmd.emit = sts.out_free;
        cmd.op   = ftr_pkg::OP_FILL;
      end
      ftr_pkg::S_OUTLINE: begin
        cmd.emit    = sts.out_free;
        cmd.op      = ftr_pkg::OP_OUTLINE;
        cmd.advance = sts.out_free;
      end
      ftr_pkg::S_GLYPH: begin
        cmd.emit    = sts.out_free;
        cmd.op      = ftr_pkg::OP_PIXEL;
        cmd.advance = sts.out_free && sts.last_px;
      end
      default: begin
        cmd.in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/ftr_dp.sv
// Datapath of the text rectangle renderer: configuration registers, cursor,
// glyph walk counters and the output register. Depends on ftr_pkg, ftr_if.
module ftr_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ftr_pkg::ftr_cmd_t cmd,
  output ftr_pkg::ftr_sts_t sts,
  ftr_in_if.sink            in_ch,
  ftr_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [15:0] origin_x_r, origin_y_r, fore_color_r, back_color_r;
  logic [7:0]  pixel_scale_r;
  logic [15:0] cur_col_r, cur_col_nxt, cur_row_r, cur_row_nxt;
  logic [5:0]  idx_r;
  logic [2:0]  col_r, row_r;
  logic [10:0] x_off_r, y_off_r;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] rect_x_r, rect_y_r, rect_color_r;
  logic [10:0] rect_w_r, rect_h_r;
  logic        draw_kind_r, last_r;

  logic [7:0]  scale;
  logic [10:0] scale_w, w5, w6, w7, w8;
  logic        accept, cfg_wr, last_px, px_on;
  logic [15:0] base_col, base_row;
  logic [6:0]  glyph_col;

  // Effective scale and its fixed multiples
  assign scale   = (pixel_scale_r == 8'd0) ? 8'd1 : pixel_scale_r;
  assign scale_w = {3'b000, scale};
  assign w5      = scale_w * 11'd5;
  assign w6      = scale_w * 11'd6;
  assign w7      = scale_w * 11'd7;
  assign w8      = {scale, 3'b000};

  assign accept  = in_ch.valid && cmd.in_ready;
  assign last_px = (col_r == ftr_pkg::GLYPH_LAST_COL) && (row_r == ftr_pkg::GLYPH_LAST_ROW);

  assign glyph_col = ftr_pkg::GLYPH_ROM[idx_r][col_r];
  assign px_on     = glyph_col[row_r];

  // Status to the sequencer
  assign sts.in_valid = in_ch.valid;
  assign sts.in_cls   = ftr_pkg::char_class(in_ch.char_code);
  assign sts.last_px  = last_px;
  assign sts.out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready = cmd.in_ready;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r    <= 16'd0;
      origin_y_r    <= 16'd0;
      fore_color_r  <= 16'hFFFF;
      back_color_r  <= 16'd0;
      pixel_scale_r <= 8'd1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ftr_pkg::REG_ORIGIN_X:    origin_x_r    <= pwdata[15:0];
        ftr_pkg::REG_ORIGIN_Y:    origin_y_r    <= pwdata[15:0];
        ftr_pkg::REG_FORE_COLOR:  fore_color_r  <= pwdata[15:0];
        ftr_pkg::REG_BACK_COLOR:  back_color_r  <= pwdata[15:0];
        ftr_pkg::REG_PIXEL_SCALE: pixel_scale_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ftr_pkg::REG_ORIGIN_X:    prdata = {16'd0, origin_x_r};
      ftr_pkg::REG_ORIGIN_Y:    prdata = {16'd0, origin_y_r};
      ftr_pkg::REG_FORE_COLOR:  prdata = {16'd0, fore_color_r};
      ftr_pkg::REG_BACK_COLOR:  prdata = {16'd0, back_color_r};
      ftr_pkg::REG_PIXEL_SCALE: prdata = {24'd0, pixel_scale_r};
      default:                  prdata = 32'd0;
    endcase
  end

  // Cursor: restart on string start, move down on newline, step after a char
  assign base_col = in_ch.string_start ? origin_x_r : cur_col_r;
  assign base_row = in_ch.string_start ? origin_y_r : cur_row_r;

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (accept) begin
      cur_col_nxt = base_col;
      cur_row_nxt = base_row;
      if (ftr_pkg::char_class(in_ch.char_code) == ftr_pkg::CLS_NEWLINE) begin
        cur_col_nxt = origin_x_r;
        cur_row_nxt = base_row + {5'd0, w8};
      end
    end else if (cmd.advance) begin
      cur_col_nxt = cur_col_r + {5'd0, w6};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= 16'd0;
      cur_row_r <= 16'd0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

  // Glyph walk: row inner, column outer, offsets track count times scale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= 3'd0;
      row_r   <= 3'd0;
      x_off_r <= 11'd0;
      y_off_r <= 11'd0;
    end else if (accept) begin
      col_r   <= 3'd0;
      row_r   <= 3'd0;
      x_off_r <= 11'd0;
      y_off_r <= 11'd0;
    end else if (cmd.emit && cmd.op == ftr_pkg::OP_PIXEL) begin
      if (row_r == ftr_pkg::GLYPH_LAST_ROW) begin
        row_r   <= 3'd0;
        y_off_r <= 11'd0;
        col_r   <= col_r + 3'd1;
        x_off_r <= x_off_r + scale_w;
      end else begin
        row_r   <= row_r + 3'd1;
        y_off_r <= y_off_r + scale_w;
      end
    end
  end

  // Hold the font row of the accepted character
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= ftr_pkg::glyph_index(in_ch.char_code);
    end
  end

  // Output register: load on emit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.op)
        ftr_pkg::OP_SPACE: begin
          rect_x_r     <= cur_col_r;
          rect_y_r     <= cur_row_r;
          rect_w_r     <= w6;
          rect_h_r     <= w7;
          rect_color_r <= back_color_r;
          draw_kind_r  <= ftr_pkg::DRAW_FILL;
          last_r       <= 1'b1;
        end
        ftr_pkg::OP_FILL: begin
          rect_x_r     <= cur_col_r;
          rect_y_r     <= cur_row_r;
          rect_w_r     <= w5;
          rect_h_r     <= w7;
          rect_color_r <= back_color_r;
          draw_kind_r  <= ftr_pkg::DRAW_FILL;
          last_r       <= 1'b0;
        end
        ftr_pkg::OP_OUTLINE: begin
          rect_x_r     <= cur_col_r;
          rect_y_r     <= cur_row_r;
          rect_w_r     <= w5;
          rect_h_r     <= w7;
          rect_color_r <= fore_color_r;
          draw_kind_r  <= ftr_pkg::DRAW_OUTLINE;
          last_r       <= 1'b1;
        end
        default: begin
          rect_x_r     <= cur_col_r + {5'd0, x_off_r};
          rect_y_r     <= cur_row_r + {5'd0, y_off_r};
          rect_w_r     <= scale_w;
          rect_h_r     <= scale_w;
          rect_color_r <= px_on ? fore_color_r : back_color_r;
          draw_kind_r  <= ftr_pkg::DRAW_FILL;
          last_r       <= last_px;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.rect_x       = rect_x_r;
  assign out_ch.rect_y       = rect_y_r;
  assign out_ch.rect_w       = rect_w_r;
  assign out_ch.rect_h       = rect_h_r;
  assign out_ch.rect_color   = rect_color_r;
  assign out_ch.draw_kind    = draw_kind_r;
  assign out_ch.last_of_char = last_r;

endmodule

FILE: sv/font_text_rect_renderer.sv
// Top level of the text rectangle renderer: joins the sequencer and datapath.
// Depends on ftr_pkg, ftr_if, ftr_ctrl and ftr_dp.
//
//   channel   | direction | protocol        | word
//   in_ch     | in        | valid/ready     | char_code, string_start
//   out_ch    | out       | valid/ready     | rect_x/y/w/h, rect_color, draw_kind, last
//   psel...   | in/out    | APB, 32-bit     | origin_x/y, fore/back_color, pixel_scale
//
// One character word is taken, then its commands leave one per cycle while out_ch
// is ready, through a single output register: a letter or digit gives 35 words,
// a space 1, any other drawn code 2, newline and code zero none. The sequencer
// handles one character at a time. Reset is synchronous (rst_n low) and restores
// register defaults, cursor at 0,0. A stalled out_ch holds the sequencer in place.
module font_text_rect_renderer (
  input  logic        clk,
  input  logic        rst_n,
  ftr_in_if.sink      in_ch,
  ftr_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ftr_pkg::ftr_cmd_t cmd;
  ftr_pkg::ftr_sts_t sts;

  ftr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  ftr_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

endmodule
